FILE: rtl/core/ipv4_udp_header_filter_macros.svh
// ----------------------------------------------------------------------------
// ipv4_udp_header_filter assertion macros
// Shared concurrent assertion forms for the header filter checker.
// ----------------------------------------------------------------------------
`ifndef IPV4_UDP_HEADER_FILTER_MACROS_SVH
`define IPV4_UDP_HEADER_FILTER_MACROS_SVH

// property checked on every clock outside reset
`define IUHF_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// property checked on every clock, reset included
`define IUHF_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

FILE: rtl/core/iuhf_pkg.sv
// ----------------------------------------------------------------------------
// iuhf_pkg
// Types and constants shared by the IPv4 UDP header filter modules.
// ----------------------------------------------------------------------------
`default_nettype none

package iuhf_pkg;

  // header byte positions
  localparam logic [15:0] POS_VERSION_IHL = 16'd0;
  localparam logic [15:0] POS_FLAGS_HI    = 16'd6;
  localparam logic [15:0] POS_FLAGS_LO    = 16'd7;
  localparam logic [15:0] POS_PROTOCOL    = 16'd9;
  localparam logic [15:0] POS_SRC_FIRST   = 16'd12;
  localparam logic [15:0] POS_SRC_LAST    = 16'd15;
  localparam logic [15:0] POS_DST_FIRST   = 16'd16;
  localparam logic [15:0] POS_DST_LAST    = 16'd19;

  localparam logic [15:0] COUNT_MAX        = 16'hFFFF;
  localparam logic [15:0] MIN_HEADER_BYTES = 16'd20;
  localparam logic [3:0]  IPV4_VERSION     = 4'd4;
  localparam logic [7:0]  UDP_PROTOCOL     = 8'h11;

  localparam int unsigned OUT_DATA_W = 88;

  typedef enum logic [2:0] {
    VERDICT_ACCEPT       = 3'd0,
    VERDICT_SHORT        = 3'd1,
    VERDICT_BAD_VERSION  = 3'd2,
    VERDICT_SHORT_HEADER = 3'd3,
    VERDICT_FRAGMENT     = 3'd4,
    VERDICT_NOT_UDP      = 3'd5
  } verdict_t;

  // captured header of one datagram, handed from front to back
  typedef struct packed {
    logic [15:0] size;
    logic [7:0]  version_ihl;
    logic [15:0] flags_offset;
    logic [7:0]  protocol_byte;
    logic [31:0] source_word;
    logic [31:0] destination_word;
  } hdr_rec_t;

  // queue status seen by the front and back
  typedef struct packed {
    logic full;
    logic valid;
  } queue_status_t;

endpackage

`default_nettype wire

FILE: rtl/core/iuhf_front.sv
// ----------------------------------------------------------------------------
// iuhf_front
// Byte counter and header capture; pushes one record per datagram.
// ----------------------------------------------------------------------------
`default_nettype none

module iuhf_front (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              s_tvalid,
  output logic                   s_tready,
  input  wire logic [7:0]        s_tdata,
  input  wire logic              s_tlast,
  input  wire logic              queue_full,
  output logic                   push,
  output iuhf_pkg::hdr_rec_t     push_rec
);
  import iuhf_pkg::*;

  logic [15:0] byte_count;
  logic [7:0]  version_ihl;
  logic [15:0] flags_offset;
  logic [7:0]  protocol_byte;
  logic [31:0] source_word;
  logic [31:0] destination_word;

  logic [15:0] byte_count_next;
  logic [7:0]  version_ihl_next;
  logic [15:0] flags_offset_next;
  logic [7:0]  protocol_byte_next;
  logic [31:0] source_word_next;
  logic [31:0] destination_word_next;
  logic        xfer;

  // a full queue only blocks the input side
  assign s_tready = !queue_full;
  assign xfer     = s_tvalid && s_tready;
  assign push     = xfer && s_tlast;

  // saturating byte count
  assign byte_count_next = (byte_count == COUNT_MAX) ? byte_count : byte_count + 16'd1;

  // capture the present byte at its header position
  always_comb begin
    version_ihl_next      = version_ihl;
    flags_offset_next     = flags_offset;
    protocol_byte_next    = protocol_byte;
    source_word_next      = source_word;
    destination_word_next = destination_word;
    priority if (byte_count == POS_VERSION_IHL) begin
      version_ihl_next = s_tdata;
    end else if (byte_count == POS_FLAGS_HI) begin
      flags_offset_next[15:8] = s_tdata;
    end else if (byte_count == POS_FLAGS_LO) begin
      flags_offset_next[7:0] = s_tdata;
    end else if (byte_count == POS_PROTOCOL) begin
      protocol_byte_next = s_tdata;
    end else if (byte_count >= POS_SRC_FIRST && byte_count <= POS_SRC_LAST) begin
      source_word_next = {source_word[23:0], s_tdata};
    end else if (byte_count >= POS_DST_FIRST && byte_count <= POS_DST_LAST) begin
      destination_word_next = {destination_word[23:0], s_tdata};
    end
  end

  // record handed to the queue on the last byte
  always_comb begin
    push_rec.size             = byte_count_next;
    push_rec.version_ihl      = version_ihl_next;
    push_rec.flags_offset     = flags_offset_next;
    push_rec.protocol_byte    = protocol_byte_next;
    push_rec.source_word      = source_word_next;
    push_rec.destination_word = destination_word_next;
  end

  // capture state, cleared after each datagram
  always_ff @(posedge clk) begin
    if (rst || push) begin
      byte_count       <= '0;
      version_ihl      <= '0;
      flags_offset     <= '0;
      protocol_byte    <= '0;
      source_word      <= '0;
      destination_word <= '0;
    end else if (xfer) begin
      byte_count       <= byte_count_next;
      version_ihl      <= version_ihl_next;
      flags_offset     <= flags_offset_next;
      protocol_byte    <= protocol_byte_next;
      source_word      <= source_word_next;
      destination_word <= destination_word_next;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/iuhf_queue.sv
// ----------------------------------------------------------------------------
// iuhf_queue
// Small record queue between the capture front and the verdict back.
// ----------------------------------------------------------------------------
`default_nettype none

module iuhf_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                push,
  input  wire iuhf_pkg::hdr_rec_t  push_rec,
  input  wire logic                pop,
  output iuhf_pkg::hdr_rec_t       head_rec,
  output iuhf_pkg::queue_status_t  status
);
  import iuhf_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  hdr_rec_t        mem [DEPTH];
  logic [AW-1:0]   wr_ptr;
  logic [AW-1:0]   rd_ptr;
  logic [CW-1:0]   fill;
  logic            do_push;
  logic            do_pop;

  assign status.full  = (fill == CW'(DEPTH));
  assign status.valid = (fill != '0);
  assign do_push      = push && !status.full;
  assign do_pop       = pop && status.valid;
  assign head_rec     = mem[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_rec;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
      if (do_push && !do_pop) begin
        fill <= fill + CW'(1);
      end else if (do_pop && !do_push) begin
        fill <= fill - CW'(1);
      end
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/iuhf_back.sv
// ----------------------------------------------------------------------------
// iuhf_back
// Verdict logic and output register for one captured header.
// ----------------------------------------------------------------------------
`default_nettype none

module iuhf_back (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire iuhf_pkg::hdr_rec_t                head_rec,
  input  wire iuhf_pkg::queue_status_t           status,
  output logic                                   pop,
  output logic                                   m_tvalid,
  input  wire logic                              m_tready,
  output logic [iuhf_pkg::OUT_DATA_W-1:0]        m_tdata,
  output logic [2:0]                             m_tuser
);
  import iuhf_pkg::*;

  verdict_t    verdict;
  logic [5:0]  hlen;
  logic        mf;
  logic        offs_nz;
  logic [16:0] payload_len;
  logic [OUT_DATA_W-1:0] data_next;

  // take a record whenever the output register is free or draining
  assign pop = status.valid && (!m_tvalid || m_tready);

  // header checks in priority order
  always_comb begin
    hlen        = {head_rec.version_ihl[3:0], 2'b00};
    mf          = head_rec.flags_offset[13];
    offs_nz     = (head_rec.flags_offset[12:8] != '0) || (head_rec.flags_offset[7:0] != '0);
    payload_len = {1'b0, head_rec.size} - {11'b0, hlen};
    priority if (head_rec.size < MIN_HEADER_BYTES) begin
      verdict = VERDICT_SHORT;
    end else if (head_rec.version_ihl[7:4] != IPV4_VERSION) begin
      verdict = VERDICT_BAD_VERSION;
    end else if (head_rec.size < {10'b0, hlen}) begin
      verdict = VERDICT_SHORT_HEADER;
    end else if (mf && offs_nz) begin
      verdict = VERDICT_FRAGMENT;
    end else if (head_rec.protocol_byte != UDP_PROTOCOL) begin
      verdict = VERDICT_NOT_UDP;
    end else begin
      verdict = VERDICT_ACCEPT;
    end
    data_next = {1'b0, payload_len, hlen, head_rec.destination_word, head_rec.source_word};
  end

  // output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (pop) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (pop) begin
      m_tdata <= data_next;
      m_tuser <= verdict;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/ipv4_udp_header_filter.sv
// The result of a datagram passes through the record queue and the output
// register; input takes one byte per cycle while the record queue is not full.
// A result waiting on the output stalls input once the record queue
// (FIFO_DEPTH entries) is full; no byte is taken until an entry drains.
// Reset (rst, synchronous, active high) clears the byte count, the captured
// header bytes, the queue and the output valid.
// ----------------------------------------------------------------------------
// ipv4_udp_header_filter
// Byte-stream IPv4 header parser giving one UDP filter verdict per datagram.
// ----------------------------------------------------------------------------
`default_nettype none

module ipv4_udp_header_filter #(
  parameter int unsigned FIFO_DEPTH = 4
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  // frame_byte
  input  wire logic                          s_tvalid,
  output logic                               s_tready,
  input  wire logic [7:0]                    s_tdata,
  input  wire logic                          s_tlast,
  // source_address [31:0], destination_address [63:32], payload_offset [69:64],
  // payload_length [86:70], zero pad [87]
  output logic                               m_tvalid,
  input  wire logic                          m_tready,
  output logic [iuhf_pkg::OUT_DATA_W-1:0]    m_tdata,
  // verdict [2:0]
  output logic [2:0]                         m_tuser
);
  import iuhf_pkg::*;

  logic          push;
  logic          pop;
  hdr_rec_t      push_rec;
  hdr_rec_t      head_rec;
  queue_status_t status;

  // capture front
  iuhf_front u_front (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tlast    (s_tlast),
    .queue_full (status.full),
    .push       (push),
    .push_rec   (push_rec)
  );

  // record queue
  iuhf_queue #(
    .DEPTH (FIFO_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_rec (push_rec),
    .pop      (pop),
    .head_rec (head_rec),
    .status   (status)
  );

  // verdict back
  iuhf_back u_back (
    .clk      (clk),
    .rst      (rst),
    .head_rec (head_rec),
    .status   (status),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

endmodule

`default_nettype wire

FILE: rtl/core/iuhf_checker.sv
// ----------------------------------------------------------------------------
// iuhf_checker
// Port-level assertions for the header filter, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "ipv4_udp_header_filter_macros.svh"

module iuhf_checker (
  input wire logic                          clk,
  input wire logic                          rst,
  input wire logic                          s_tvalid,
  input wire logic                          s_tready,
  input wire logic [7:0]                    s_tdata,
  input wire logic                          s_tlast,
  input wire logic                          m_tvalid,
  input wire logic                          m_tready,
  input wire logic [iuhf_pkg::OUT_DATA_W-1:0] m_tdata,
  input wire logic [2:0]                    m_tuser
);
  import iuhf_pkg::*;

  // stalled result holds
  `IUHF_ASSERT(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled result changed")

  // verdict code in range
  `IUHF_ASSERT(a_verdict_range, m_tvalid |-> m_tuser <= VERDICT_NOT_UDP, "verdict out of range")

  // accepted datagram never has a negative payload length
  `IUHF_ASSERT(a_accept_len, m_tvalid && m_tuser == VERDICT_ACCEPT |-> !m_tdata[86] && !m_tdata[87], "accepted with negative length")

  // no result right after reset
  `IUHF_ASSERT_ALWAYS(a_reset_idle, $past(rst) |-> !m_tvalid, "result valid after reset")

endmodule

bind ipv4_udp_header_filter iuhf_checker u_iuhf_checker (.*);

`default_nettype wire

FILE: tb/sv/ipv4_udp_header_filter_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ipv4_udp_header_filter_checker
// Watches both stream channels of the header filter and tracks every input
// byte in its own copy of the parser state. On each last byte it computes
// the verdict with its fields, and compares each output transfer with the
// oldest verdict still due.
// ----------------------------------------------------------------------------

module ipv4_udp_header_filter_checker (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  input  wire logic        s_tready,
  input  wire logic [7:0]  s_tdata,
  input  wire logic        s_tlast,
  input  wire logic        m_tvalid,
  input  wire logic        m_tready,
  input  wire logic [87:0] m_tdata,
  input  wire logic [2:0]  m_tuser,
  output int unsigned      mismatches,
  output int unsigned      outstanding
);

  import iuhf_pkg::*;

  // one verdict with its fields
  typedef struct packed {
    verdict_t    verdict;
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic [5:0]  hdr_bytes;
    logic [16:0] payload_len;
  } filter_result_t;

  filter_result_t verdicts_due[$];

  // parser state of the datagram in flight
  logic [15:0] byte_cnt;
  logic [7:0]  ver_ihl;
  logic [15:0] frag_word;
  logic [7:0]  proto;
  logic [31:0] src_acc;
  logic [31:0] dst_acc;
  int unsigned fail_total;

  always @(posedge clk) begin : watch
    logic [15:0]    size;
    logic [5:0]     hdr;
    logic [7:0]     frag_off;
    filter_result_t want;
    filter_result_t got;
    if (rst) begin
      byte_cnt   = '0;
      ver_ihl    = '0;
      frag_word  = '0;
      proto      = '0;
      src_acc    = '0;
      dst_acc    = '0;
      fail_total = 0;
      verdicts_due.delete();
    end else begin
      // output transfer against the oldest verdict due
      if (m_tvalid && m_tready) begin
        got.verdict     = verdict_t'(m_tuser);
        got.src_addr    = m_tdata[31:0];
        got.dst_addr    = m_tdata[63:32];
        got.hdr_bytes   = m_tdata[69:64];
        got.payload_len = m_tdata[86:70];
        if (verdicts_due.size() == 0) begin
          $display("%0t: result transfer with no datagram pending: verdict %0d src %h dst %h",
                   $time, got.verdict, got.src_addr, got.dst_addr);
          fail_total++;
        end else begin
          want = verdicts_due.pop_front();
          if (got.verdict != want.verdict) begin
            $display("%0t: verdict expected %0d actual %0d", $time, want.verdict, got.verdict);
            fail_total++;
          end
          if (got.src_addr != want.src_addr) begin
            $display("%0t: source address expected %h actual %h",
                     $time, want.src_addr, got.src_addr);
            fail_total++;
          end
          if (got.dst_addr != want.dst_addr) begin
            $display("%0t: destination address expected %h actual %h",
                     $time, want.dst_addr, got.dst_addr);
            fail_total++;
          end
          if (got.hdr_bytes != want.hdr_bytes) begin
            $display("%0t: payload offset expected %0d actual %0d",
                     $time, want.hdr_bytes, got.hdr_bytes);
            fail_total++;
          end
          if (got.payload_len != want.payload_len) begin
            $display("%0t: payload length expected %h actual %h",
                     $time, want.payload_len, got.payload_len);
            fail_total++;
          end
        end
      end

      // input transfer: capture, count, and judge on the last byte
      if (s_tvalid && s_tready) begin
        if (byte_cnt == POS_VERSION_IHL) begin
          ver_ihl = s_tdata;
        end else if (byte_cnt == POS_FLAGS_HI) begin
          frag_word[15:8] = s_tdata;
        end else if (byte_cnt == POS_FLAGS_LO) begin
          frag_word[7:0] = s_tdata;
        end else if (byte_cnt == POS_PROTOCOL) begin
          proto = s_tdata;
        end else if (byte_cnt >= POS_SRC_FIRST && byte_cnt <= POS_SRC_LAST) begin
          src_acc = {src_acc[23:0], s_tdata};
        end else if (byte_cnt >= POS_DST_FIRST && byte_cnt <= POS_DST_LAST) begin
          dst_acc = {dst_acc[23:0], s_tdata};
        end
        if (byte_cnt != COUNT_MAX) begin
          byte_cnt = byte_cnt + 16'd1;
        end

        if (s_tlast) begin
          size = byte_cnt;
          hdr  = {ver_ihl[3:0], 2'b00};
          // offset test ors the two offset bytes rather than joining them
          frag_off = {3'b000, frag_word[12:8]} | frag_word[7:0];
          if (size < MIN_HEADER_BYTES) begin
            want.verdict = VERDICT_SHORT;
          end else if (ver_ihl[7:4] != IPV4_VERSION) begin
            want.verdict = VERDICT_BAD_VERSION;
          end else if (size < {10'd0, hdr}) begin
            want.verdict = VERDICT_SHORT_HEADER;
          end else if (frag_word[13] && frag_off != 8'd0) begin
            want.verdict = VERDICT_FRAGMENT;
          end else if (proto != UDP_PROTOCOL) begin
            want.verdict = VERDICT_NOT_UDP;
          end else begin
            want.verdict = VERDICT_ACCEPT;
          end
          want.src_addr    = src_acc;
          want.dst_addr    = dst_acc;
          want.hdr_bytes   = hdr;
          want.payload_len = {1'b0, size} - {11'd0, hdr};
          verdicts_due.push_back(want);

          byte_cnt  = '0;
          ver_ihl   = '0;
          frag_word = '0;
          proto     = '0;
          src_acc   = '0;
          dst_acc   = '0;
        end
      end
    end
    mismatches  <= fail_total;
    outstanding <= verdicts_due.size();
  end

endmodule

FILE: tb/sv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Drives IPv4 datagrams byte by byte into the header filter: a directed set
// covering each verdict, field extremes and the fragment rule, then random
// datagrams, mostly well formed, under several idle and stall mixes with
// one long output hold-off.
// The checker beside the block predicts and compares every verdict.
// ----------------------------------------------------------------------------

module tb_top;

  import iuhf_pkg::*;

  localparam int unsigned QUIET_LIMIT  = 4000;
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam int unsigned PHASE_BYTES  = 190;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = '0;
  logic        s_tlast = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [87:0] m_tdata;
  logic [2:0]  m_tuser;

  int unsigned mismatches;
  int unsigned outstanding;
  int unsigned bytes_sent = 0;
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned hold_asked = 0;
  int unsigned hold_served = 0;
  int unsigned hold_left = 0;
  int unsigned quiet_cycles = 0;

  // 8 ns clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  ipv4_udp_header_filter dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  ipv4_udp_header_filter_checker filter_chk (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tlast     (s_tlast),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tuser     (m_tuser),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  // output side: random stalls, or a long hold-off when one is asked for
  always @(posedge clk) begin
    if (hold_left != 0) begin
      m_tready  <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_served != hold_asked) begin
      m_tready    <= 1'b0;
      hold_left   <= HOLD_CYCLES;
      hold_served <= hold_asked;
    end else begin
      m_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // one byte transfer, with random idle cycles ahead of it
  task automatic send_byte(input logic [7:0] value, input logic is_last);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= value;
    s_tlast  <= is_last;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    bytes_sent++;
  endtask

  // datagram of the given length; bytes outside the parsed fields are random
  task automatic send_datagram(input logic [3:0] ver, input logic [3:0] ihl,
                               input logic [15:0] flags, input logic [7:0] proto,
                               input logic [31:0] src, input logic [31:0] dst,
                               input int unsigned total);
    logic [7:0] b;
    for (int unsigned i = 0; i < total; i++) begin
      b = 8'($urandom);
      if (i == POS_VERSION_IHL) begin
        b = {ver, ihl};
      end else if (i == POS_FLAGS_HI) begin
        b = flags[15:8];
      end else if (i == POS_FLAGS_LO) begin
        b = flags[7:0];
      end else if (i == POS_PROTOCOL) begin
        b = proto;
      end else if (i >= POS_SRC_FIRST && i <= POS_SRC_LAST) begin
        b = src[8*(POS_SRC_LAST - i) +: 8];
      end else if (i >= POS_DST_FIRST && i <= POS_DST_LAST) begin
        b = dst[8*(POS_DST_LAST - i) +: 8];
      end
      send_byte(b, i == total - 1);
    end
  endtask

  // mostly well-formed datagrams, some with random header, some short
  task automatic send_random_datagram();
    int unsigned pick;
    int unsigned ihl_v;
    int unsigned total;
    logic [3:0]  ver;
    logic [15:0] flags;
    logic [7:0]  proto;
    pick  = $urandom_range(99);
    ver   = IPV4_VERSION;
    ihl_v = ($urandom_range(4) == 0) ? $urandom_range(15, 5) : 5;
    case ($urandom_range(3))
      0: flags = 16'h0000;
      1: flags = 16'h2000;
      2: flags = 16'($urandom);
      default: flags = {3'($urandom), 13'd0};
    endcase
    proto = ($urandom_range(3) != 0) ? UDP_PROTOCOL : 8'($urandom);
    total = ihl_v * 4 + $urandom_range(12);
    if (pick >= 85) begin
      total = $urandom_range(19, 1);
    end else if (pick >= 70) begin
      ver   = 4'($urandom);
      ihl_v = $urandom_range(15);
      total = $urandom_range(64, 1);
    end else if (pick >= 62) begin
      // header claims more bytes than the frame holds
      ihl_v = $urandom_range(15, 6);
      total = $urandom_range(ihl_v * 4 - 1, 20);
    end
    send_datagram(ver, 4'(ihl_v), flags, proto, $urandom, $urandom, total);
  endtask

  task automatic run_traffic(input int unsigned budget);
    int unsigned start;
    start = bytes_sent;
    while (bytes_sent - start < budget) send_random_datagram();
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed datagrams, no idling
    send_datagram(4'd4, 4'd5, 16'h0000, UDP_PROTOCOL, 32'hFFFF_FFFF, 32'h0000_0000, 28);
    send_datagram(4'd4, 4'd5, 16'h4000, UDP_PROTOCOL, 32'h0000_0000, 32'hFFFF_FFFF, 20);
    send_byte(8'hFF, 1'b1);
    send_datagram(4'd4, 4'd5, 16'h0000, UDP_PROTOCOL, 32'h0102_0304, 32'h0506_0708, 19);
    send_datagram(4'd6, 4'd5, 16'h0000, UDP_PROTOCOL, 32'hA5A5_5A5A, 32'h5A5A_A5A5, 20);
    send_datagram(4'd0, 4'd0, 16'h0000, 8'h00, 32'h1111_1111, 32'h2222_2222, 24);
    send_datagram(4'd4, 4'd15, 16'h0000, UDP_PROTOCOL, 32'hC0A8_0001, 32'hC0A8_00FE, 40);
    send_datagram(4'd4, 4'd15, 16'h0000, UDP_PROTOCOL, 32'hC0A8_0002, 32'hC0A8_00FD, 60);
    send_datagram(4'd4, 4'd5, 16'h2001, UDP_PROTOCOL, 32'h0A00_0001, 32'h0A00_0002, 30);
    send_datagram(4'd4, 4'd5, 16'h3F00, UDP_PROTOCOL, 32'h0A00_0003, 32'h0A00_0004, 30);
    send_datagram(4'd4, 4'd5, 16'h1FFF, UDP_PROTOCOL, 32'h0A00_0005, 32'h0A00_0006, 30);
    send_datagram(4'd4, 4'd5, 16'hE000, UDP_PROTOCOL, 32'h0A00_0007, 32'h0A00_0008, 25);
    send_datagram(4'd4, 4'd5, 16'h0000, 8'h06, 32'h7F00_0001, 32'h7F00_0001, 26);
    send_datagram(4'd4, 4'd5, 16'h0000, 8'hFF, 32'h8000_0000, 32'h0000_0001, 21);
    send_datagram(4'd15, 4'd1, 16'hFFFF, 8'h11, 32'hDEAD_BEEF, 32'hFEED_F00D, 33);

    // free-running phase
    run_traffic(PHASE_BYTES);

    // long output hold-off while one-byte frames keep coming
    hold_asked <= hold_asked + 1;
    for (int unsigned k = 0; k < 24; k++) send_byte(8'($urandom), 1'b1);

    // sender idle most of the time
    send_idle_pct = 80;
    run_traffic(PHASE_BYTES);

    // receiver stalling most of the time
    send_idle_pct = 0;
    stall_pct    <= 80;
    run_traffic(PHASE_BYTES);

    // both sides idling a third of the time
    send_idle_pct = 33;
    stall_pct    <= 33;
    run_traffic(PHASE_BYTES);

    // drain
    s_tvalid  <= 1'b0;
    stall_pct <= 0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
